FILE: src/cht_pkg.sv
// cht_pkg: shared constants, opcodes and control structs of the chained hash table
// no dependencies
`default_nettype none

package cht_pkg;

  localparam int BASE_BUCKET_COUNT = 7;
  localparam int NUM_BUCKETS_DEF    = BASE_BUCKET_COUNT;
  localparam int BUCKET_DEPTH_DEF   = 8;
  localparam int KEY_BITS_DEF       = 32;
  localparam int VALUE_BITS_DEF     = 32;

  localparam int OPCODE_BITS      = 2;
  localparam int ENTRY_COUNT_BITS = 6;
  localparam int CHUNK_BITS       = 8;

  localparam logic [OPCODE_BITS-1:0] OP_UPDATE = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic setup;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_search;
    logic mod_last;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/cht_ctrl.sv
// cht_ctrl: sequencing state machine of the chained hash table
// depends on cht_pkg; drives commands into cht_dp and reads its status
`default_nettype none

module cht_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire cht_pkg::sts_t sts,
  output cht_pkg::cmd_t     cmd
);
  import cht_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (!sts.need_search) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mod_step = 1'b1;
          if (sts.mod_last) state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

FILE: src/cht_dp.sv
// cht_dp: datapath of the chained hash table: bucket remainder unit, slot memory,
// fill counters and result register; depends on cht_pkg, commanded by cht_ctrl
`default_nettype none

module cht_dp #(
  parameter int NUM_BUCKETS  = cht_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF,
  parameter int KEY_BITS     = cht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS   = cht_pkg::VALUE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire cht_pkg::cmd_t                      cmd,
  output cht_pkg::sts_t                           sts,
  input  wire logic [cht_pkg::OPCODE_BITS-1:0]    in_opcode,
  input  wire logic [KEY_BITS-1:0]                in_key,
  input  wire logic [VALUE_BITS-1:0]              in_new_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_hit,
  output logic [VALUE_BITS-1:0]                   out_found_value,
  output logic                                    out_bucket_full,
  output logic [cht_pkg::ENTRY_COUNT_BITS-1:0]    out_entry_count
);
  import cht_pkg::*;

  localparam int SLOTS   = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RB      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int FW      = $clog2(BUCKET_DEPTH + 1);
  localparam int IW      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int NCHUNK  = (KEY_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int KPAD    = NCHUNK * CHUNK_BITS;
  localparam int CW      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int EW      = KEY_BITS + VALUE_BITS;
  localparam logic [RB:0] NB_EXT = (RB + 1)'(NUM_BUCKETS);

  // one key bit per step: r = (2r + bit) mod NUM_BUCKETS
  function automatic logic [RB-1:0] mod_fold(input logic [RB-1:0] r_in,
                                             input logic [CHUNK_BITS-1:0] chunk);
    logic [RB:0] acc;
    acc = {1'b0, r_in};
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      acc = {acc[RB-1:0], chunk[i]};
      if (acc >= NB_EXT) acc = acc - NB_EXT;
    end
    return acc[RB-1:0];
  endfunction

  logic [OPCODE_BITS-1:0]      op_r;
  logic [KEY_BITS-1:0]         key_r;
  logic [VALUE_BITS-1:0]       val_r;
  logic [KPAD-1:0]             key_sh_r;
  logic [CW-1:0]               chunk_cnt_r;
  logic [RB-1:0]               rem_r;
  logic [RB-1:0]               bucket_r;
  logic [AW-1:0]               base_r;
  logic [FW-1:0]               fill_sel_r;
  logic [FW-1:0]               scan_idx_r;
  logic                        cmp_valid_r;
  logic [IW-1:0]               cmp_idx_r;
  logic                        hit_r;
  logic [FW-1:0]               fill_r [NUM_BUCKETS];
  logic [ENTRY_COUNT_BITS-1:0] total_r;
  logic [EW-1:0]               mem [SLOTS];
  logic [EW-1:0]               rdata_r;

  logic                        out_valid_r, out_hit_r, out_full_r;
  logic [VALUE_BITS-1:0]       out_value_r;
  logic [ENTRY_COUNT_BITS-1:0] out_count_r;

  logic                        match;
  logic                        mem_re, mem_we;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic                        bucket_is_full;
  logic                        append;
  logic [ENTRY_COUNT_BITS-1:0] total_nxt;
  logic                        res_full;
  logic [VALUE_BITS-1:0]       res_value;

  assign match = cmp_valid_r && (rdata_r[EW-1 -: KEY_BITS] == key_r);
  assign bucket_is_full = (fill_sel_r == FW'(BUCKET_DEPTH));

  assign sts.need_search = (op_r == OP_UPDATE) || (op_r == OP_LOOKUP);
  assign sts.mod_last    = (chunk_cnt_r == '0);
  assign sts.scan_done   = match || (scan_idx_r >= fill_sel_r);
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign mem_re  = cmd.scan && !match && (scan_idx_r < fill_sel_r);
  assign rd_addr = base_r + AW'(scan_idx_r);

  always_comb begin
    mem_we    = 1'b0;
    append    = 1'b0;
    wr_addr   = base_r + AW'(cmp_idx_r);
    total_nxt = total_r;
    res_full  = 1'b0;
    res_value = '0;
    case (op_r)
      OP_UPDATE: begin
        if (hit_r) begin
          mem_we = cmd.commit;
        end else if (bucket_is_full) begin
          res_full = 1'b1;
        end else begin
          mem_we    = cmd.commit;
          append    = cmd.commit;
          wr_addr   = base_r + AW'(fill_sel_r);
          total_nxt = total_r + 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (hit_r) res_value = rdata_r[VALUE_BITS-1:0];
      end
      OP_CLEAR: begin
        total_nxt = '0;
      end
      default: total_nxt = total_r;
    endcase
  end

  // slot memory: key in the upper bits, value in the lower
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= {key_r, val_r};
    if (mem_re) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_opcode;
      key_r       <= in_key;
      val_r       <= in_new_value;
      key_sh_r    <= KPAD'(in_key);
      chunk_cnt_r <= CW'(NCHUNK - 1);
      rem_r       <= '0;
      hit_r       <= 1'b0;
    end
    if (cmd.mod_step) begin
      rem_r       <= mod_fold(rem_r, key_sh_r[KPAD-1 -: CHUNK_BITS]);
      key_sh_r    <= key_sh_r << CHUNK_BITS;
      chunk_cnt_r <= chunk_cnt_r - 1'b1;
    end
    if (cmd.setup) begin
      bucket_r   <= rem_r;
      base_r     <= AW'(AW'(rem_r) * AW'(BUCKET_DEPTH));
      fill_sel_r <= fill_r[rem_r];
      scan_idx_r <= '0;
      hit_r      <= 1'b0;
    end
    if (cmd.scan) begin
      if (match) begin
        hit_r <= 1'b1;
      end else if (mem_re) begin
        cmp_idx_r  <= scan_idx_r[IW-1:0];
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end
    if (cmd.commit) begin
      out_hit_r   <= hit_r;
      out_value_r <= res_value;
      out_full_r  <= res_full;
      out_count_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      for (int b = 0; b < NUM_BUCKETS; b++) fill_r[b] <= '0;
    end else begin
      if (cmd.setup) cmp_valid_r <= 1'b0;
      else if (cmd.scan) cmp_valid_r <= mem_re;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        total_r     <= total_nxt;
        if (append) fill_r[bucket_r] <= fill_sel_r + 1'b1;
        if (op_r == OP_CLEAR) begin
          for (int b = 0; b < NUM_BUCKETS; b++) fill_r[b] <= '0;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_found_value = out_value_r;
  assign out_bucket_full = out_full_r;
  assign out_entry_count = out_count_r;

endmodule

`default_nettype wire

FILE: src/chained_hash_table.sv
// chained_hash_table: top level, joins the controller and the datapath
// depends on cht_pkg, cht_ctrl and cht_dp
//
// usage:
//   request channel in_*: in_opcode (update, lookup, clear), in_key, in_new_value,
//   taken when in_valid is high and in_stall low. result channel out_*: out_hit,
//   out_found_value, out_bucket_full, out_entry_count, taken when out_valid is
//   high and out_stall low. exactly one result per request, in order.
//   one request at a time: in_stall is high from acceptance until the result is
//   loaded into the output register. update and lookup pass an accept step, the
//   bucket remainder unit (8 key bits per cycle), a setup step, a scan of the
//   bucket through the one-read-port slot memory (one slot per cycle, stops early
//   on a hit) and a finish step. clear and the unused opcode skip the remainder
//   unit, the setup step and the scan.
//   the next request is taken while a result still waits in the output register;
//   a stalled receiver only holds the finish step of the following request.
//   reset empties all buckets and the entry count and drops a pending result;
//   clearing uses per-bucket fill counters, so no memory sweep is needed.
`default_nettype none

module chained_hash_table #(
  parameter int NUM_BUCKETS  = cht_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF,
  parameter int KEY_BITS     = cht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS   = cht_pkg::VALUE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [cht_pkg::OPCODE_BITS-1:0]    in_opcode,
  input  wire logic [KEY_BITS-1:0]                in_key,
  input  wire logic [VALUE_BITS-1:0]              in_new_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_hit,
  output logic [VALUE_BITS-1:0]                   out_found_value,
  output logic                                    out_bucket_full,
  output logic [cht_pkg::ENTRY_COUNT_BITS-1:0]    out_entry_count
);
  import cht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cht_dp #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .KEY_BITS     (KEY_BITS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_found_value (out_found_value),
    .out_bucket_full (out_bucket_full),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire

FILE: src/cht_checker.sv
// cht_checker: port-level assertions for chained_hash_table, bound to the top level
// depends on cht_pkg and the chained_hash_table ports
`default_nettype none

module cht_checker #(
  parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  out_hit,
  input wire logic [VALUE_BITS-1:0] out_found_value,
  input wire logic                  out_bucket_full
);

  logic       in_acc, out_acc;
  logic [1:0] pending_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // requests accepted but whose result is not yet taken
  always_ff @(posedge clk) begin
    if (!rst_n) pending_r <= '0;
    else        pending_r <= pending_r + {1'b0, in_acc} - {1'b0, out_acc};
  end

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_value_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_found_value))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("second request taken while one is in work");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 2'd2)
    else $error("too many requests outstanding");

  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bucket_full |-> !out_hit && (out_found_value == '0))
    else $error("dropped insert reported a hit");

endmodule

bind chained_hash_table cht_checker #(.VALUE_BITS(VALUE_BITS)) u_cht_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_hit         (out_hit),
  .out_found_value (out_found_value),
  .out_bucket_full (out_bucket_full)
);

`default_nettype wire
